// ===== hw/rtl/first_fit_free_list_allocator_unit_macros.svh =====
// Assertion macros for the first-fit free list allocator.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define FFA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Check that cons holds in the cycle after ante.
`define FFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

// ===== hw/rtl/ffa_pkg.sv =====
// Shared constants, types and helper functions of the free list allocator.
package ffa_pkg;

    localparam int FREE_ENTRIES = 64;
    localparam int ADDR_W       = 16;
    localparam int BYTES_W      = 16;
    localparam int LEN_W        = 17;
    localparam int CNT_W        = 32;
    localparam int PARA_SHIFT   = 4;
    localparam int PARA_W       = BYTES_W - PARA_SHIFT;
    localparam int IDX_W        = $clog2(FREE_ENTRIES);
    localparam int COUNT_W      = $clog2(FREE_ENTRIES + 1);
    localparam int SUM_W        = LEN_W + COUNT_W;
    localparam int ENT_W        = ADDR_W + LEN_W;

    localparam logic [BYTES_W-1:0] ROUND_ADD  = BYTES_W'(15);
    localparam logic [BYTES_W-1:0] ROUND_MASK = BYTES_W'(16'hfff0);
    localparam logic [LEN_W-1:0]   LEN_MAX    = {LEN_W{1'b1}};
    localparam logic [CNT_W-1:0]   CNT_MAX    = {CNT_W{1'b1}};

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } t_entry;

    function automatic logic [PARA_W-1:0] to_paragraphs(input logic [BYTES_W-1:0] bytes);
        logic [BYTES_W-1:0] s;
        s = (bytes + ROUND_ADD) & ROUND_MASK;
        return s[BYTES_W-1:PARA_SHIFT];
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/ffa_in_if.sv =====
// Request channel of the allocator: valid, ready and the request fields.
interface ffa_in_if;
    import ffa_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [BYTES_W-1:0] request_bytes;
    logic [ADDR_W-1:0]  free_address;

    modport source (output valid, output mode, output request_bytes,
                    output free_address, input ready);
    modport sink   (input valid, input mode, input request_bytes,
                    input free_address, output ready);
endinterface

// ===== hw/rtl/ffa_out_if.sv =====
// Result channel of the allocator: valid, ready and the result fields.
interface ffa_out_if;
    import ffa_pkg::*;

    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  alloc_address;
    logic               failed;
    logic [LEN_W-1:0]   free_total;
    logic [COUNT_W-1:0] entries_in_use;
    logic [COUNT_W-1:0] max_entries_seen;
    logic [CNT_W-1:0]   lost_count;
    logic [CNT_W-1:0]   lost_paragraphs;

    modport source (output valid, output alloc_address, output failed,
                    output free_total, output entries_in_use, output max_entries_seen,
                    output lost_count, output lost_paragraphs, input ready);
    modport sink   (input valid, input alloc_address, input failed,
                    input free_total, input entries_in_use, input max_entries_seen,
                    input lost_count, input lost_paragraphs, output ready);
endinterface

// ===== hw/rtl/first_fit_free_list_allocator_unit.sv =====
// First-fit free list allocator: sequencer over one entry RAM.
// Steps: a free that inserts ahead of an entry scans for its place, decides, shifts the tail up
// one place, writes the new entry and loads the result; search and shift are separate passes.
// Flow: one item at a time; the next is taken once the sequencer is back in idle,
// when the result is registered; a stalled result holds the sequencer.
// Reset (synchronous, active low) empties the list and clears the counters; RAM needs no clear.
module first_fit_free_list_allocator_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    ffa_in_if.sink    i_in,
    ffa_out_if.source o_out
);
    import ffa_pkg::*;

    `include "first_fit_free_list_allocator_unit_macros.svh"

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_SHDN   = 3'd3;
    localparam logic [2:0] ST_SHUP   = 3'd4;
    localparam logic [2:0] ST_INS    = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;

    // control state
    logic [2:0]         r_state, n_state;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_peak, n_peak;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_loss_n, n_loss_n;
    logic [CNT_W-1:0]   r_loss_p, n_loss_p;
    logic               r_ovalid, n_ovalid;

    // working registers of the current item
    logic               r_mode, n_mode;
    logic [PARA_W-1:0]  r_len, n_len;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [IDX_W-1:0]   r_ci, n_ci;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [COUNT_W-1:0] r_k, n_k;
    logic               r_kin, n_kin;
    logic               r_hasprev, n_hasprev;
    t_entry             r_prev, n_prev;
    t_entry             r_cur, n_cur;
    logic [ADDR_W-1:0]  r_res_addr, n_res_addr;
    logic               r_res_fail, n_res_fail;

    // result register
    logic [ADDR_W-1:0]  r_o_addr, n_o_addr;
    logic               r_o_fail, n_o_fail;
    logic [LEN_W-1:0]   r_o_total, n_o_total;
    logic [COUNT_W-1:0] r_o_count, n_o_count;
    logic [COUNT_W-1:0] r_o_peak, n_o_peak;
    logic [CNT_W-1:0]   r_o_loss_n, n_o_loss_n;
    logic [CNT_W-1:0]   r_o_loss_p, n_o_loss_p;

    // entry RAM
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_entry             ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    t_entry             q;

    ffa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (FREE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (q)
    );

    logic               in_acc;
    logic [LEN_W-1:0]   len_ext;
    logic [LEN_W-1:0]   q_left;
    logic               q_fits;
    logic [LEN_W:0]     prev_end;
    logic [ADDR_W:0]    addr_end;
    logic               adj_prev;
    logic               adj_cur;
    logic [LEN_W-1:0]   m1;
    logic [LEN_W-1:0]   m2;
    logic [LEN_W-1:0]   m_cur;
    logic [CNT_W:0]     loss_sum;
    logic [COUNT_W-1:0] ci_next;
    logic               out_free;

    assign in_acc   = i_in.valid && i_in.ready;
    assign len_ext  = LEN_W'(r_len);
    assign q_fits   = q.len >= len_ext;
    assign q_left   = q.len - len_ext;
    assign prev_end = {1'b0, r_prev.start} + {1'b0, r_prev.len};
    assign addr_end = {1'b0, r_addr} + (ADDR_W + 1)'(r_len);
    assign adj_prev = r_hasprev && (prev_end == (LEN_W + 1)'(r_addr));
    assign adj_cur  = r_kin && (addr_end == {1'b0, r_cur.start});
    assign m1       = sat_len(r_prev.len, len_ext);
    assign m2       = adj_cur ? sat_len(m1, r_cur.len) : m1;
    assign m_cur    = sat_len(r_cur.len, len_ext);
    assign loss_sum = {1'b0, r_loss_p} + (CNT_W + 1)'(r_len);
    assign ci_next  = COUNT_W'(r_ci) + COUNT_W'(1);
    assign out_free = !r_ovalid || o_out.ready;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_peak     = r_peak;
        n_sum      = r_sum;
        n_loss_n   = r_loss_n;
        n_loss_p   = r_loss_p;
        n_ovalid   = r_ovalid;
        n_mode     = r_mode;
        n_len      = r_len;
        n_addr     = r_addr;
        n_ci       = r_ci;
        n_j        = r_j;
        n_k        = r_k;
        n_kin      = r_kin;
        n_hasprev  = r_hasprev;
        n_prev     = r_prev;
        n_cur      = r_cur;
        n_res_addr = r_res_addr;
        n_res_fail = r_res_fail;
        n_o_addr   = r_o_addr;
        n_o_fail   = r_o_fail;
        n_o_total  = r_o_total;
        n_o_count  = r_o_count;
        n_o_peak   = r_o_peak;
        n_o_loss_n = r_o_loss_n;
        n_o_loss_p = r_o_loss_p;
        ram_we     = 1'b0;
        ram_waddr  = r_ci;
        ram_wdata  = q;
        ram_raddr  = '0;

        // drop the result once the sink takes it
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                // read entry zero so the scan starts with data in hand
                ram_raddr = '0;
                if (in_acc) begin
                    n_mode     = i_in.mode;
                    n_len      = to_paragraphs(i_in.request_bytes);
                    n_addr     = i_in.free_address;
                    n_ci       = '0;
                    n_hasprev  = 1'b0;
                    n_res_addr = '0;
                    n_res_fail = 1'b0;
                    if (r_count == '0) begin
                        if (i_in.mode == MODE_ALLOC) begin
                            n_res_fail = 1'b1;
                            n_state    = ST_FIN;
                        end else begin
                            n_k     = '0;
                            n_kin   = 1'b0;
                            n_state = ST_DECIDE;
                        end
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // q holds entry r_ci; fetch the next one meanwhile
                ram_raddr = r_ci + IDX_W'(1);
                if (r_mode == MODE_ALLOC) begin
                    if (q_fits) begin
                        n_res_addr = q.start;
                        n_sum      = r_sum - SUM_W'(r_len);
                        if (q_left != '0) begin
                            ram_we          = 1'b1;
                            ram_waddr       = r_ci;
                            ram_wdata.start = q.start + ADDR_W'(r_len);
                            ram_wdata.len   = q_left;
                            n_state         = ST_FIN;
                        end else begin
                            // entry empties: close the gap above it
                            n_count = r_count - COUNT_W'(1);
                            n_j     = r_ci;
                            n_state = (ci_next < r_count) ? ST_SHDN : ST_FIN;
                        end
                    end else if (ci_next == r_count) begin
                        n_res_fail = 1'b1;
                        n_state    = ST_FIN;
                    end else begin
                        n_ci = r_ci + IDX_W'(1);
                    end
                end else begin
                    if (q.start > r_addr) begin
                        n_k     = COUNT_W'(r_ci);
                        n_kin   = 1'b1;
                        n_cur   = q;
                        n_state = ST_DECIDE;
                    end else begin
                        n_prev    = q;
                        n_hasprev = 1'b1;
                        if (ci_next == r_count) begin
                            n_k     = r_count;
                            n_kin   = 1'b0;
                            n_state = ST_DECIDE;
                        end else begin
                            n_ci = r_ci + IDX_W'(1);
                        end
                    end
                end
            end

            ST_DECIDE: begin
                ram_raddr = IDX_W'(r_k + COUNT_W'(1));
                if (adj_prev) begin
                    // grow the entry below, and absorb the one above if it touches
                    ram_we          = 1'b1;
                    ram_waddr       = IDX_W'(r_k - COUNT_W'(1));
                    ram_wdata.start = r_prev.start;
                    ram_wdata.len   = m2;
                    n_sum = r_sum + SUM_W'(m2) - SUM_W'(r_prev.len)
                          - (adj_cur ? SUM_W'(r_cur.len) : SUM_W'(0));
                    if (adj_cur) begin
                        n_count = r_count - COUNT_W'(1);
                        n_j     = IDX_W'(r_k);
                        n_state = ((r_k + COUNT_W'(1)) < r_count) ? ST_SHDN : ST_FIN;
                    end else begin
                        n_state = ST_FIN;
                    end
                end else if (adj_cur) begin
                    ram_we          = 1'b1;
                    ram_waddr       = IDX_W'(r_k);
                    ram_wdata.start = r_addr;
                    ram_wdata.len   = m_cur;
                    n_sum   = r_sum + SUM_W'(m_cur) - SUM_W'(r_cur.len);
                    n_state = ST_FIN;
                end else if (r_count < COUNT_W'(FREE_ENTRIES)) begin
                    n_count = r_count + COUNT_W'(1);
                    if ((r_count + COUNT_W'(1)) > r_peak) begin
                        n_peak = r_count + COUNT_W'(1);
                    end
                    n_sum = r_sum + SUM_W'(r_len);
                    if (r_kin) begin
                        // open a slot at k by moving the tail up one place
                        ram_raddr = IDX_W'(r_count - COUNT_W'(1));
                        n_j       = IDX_W'(r_count);
                        n_state   = ST_SHUP;
                    end else begin
                        ram_we          = 1'b1;
                        ram_waddr       = IDX_W'(r_k);
                        ram_wdata.start = r_addr;
                        ram_wdata.len   = len_ext;
                        n_state         = ST_FIN;
                    end
                end else begin
                    // list full: count the lost block
                    n_res_fail = 1'b1;
                    if (r_loss_n != CNT_MAX) begin
                        n_loss_n = r_loss_n + CNT_W'(1);
                    end
                    n_loss_p = loss_sum[CNT_W] ? CNT_MAX : loss_sum[CNT_W-1:0];
                    n_state  = ST_FIN;
                end
            end

            ST_SHDN: begin
                // q holds entry r_j + 1; move it down to r_j
                ram_raddr = r_j + IDX_W'(2);
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = q;
                if ((COUNT_W'(r_j) + COUNT_W'(1)) == r_count) begin
                    n_state = ST_FIN;
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end

            ST_SHUP: begin
                // q holds entry r_j - 1; move it up to r_j
                ram_raddr = r_j - IDX_W'(2);
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = q;
                if (COUNT_W'(IDX_W'(r_j - IDX_W'(1))) == r_k) begin
                    n_state = ST_INS;
                end else begin
                    n_j = r_j - IDX_W'(1);
                end
            end

            ST_INS: begin
                ram_we          = 1'b1;
                ram_waddr       = IDX_W'(r_k);
                ram_wdata.start = r_addr;
                ram_wdata.len   = len_ext;
                n_state         = ST_FIN;
            end

            ST_FIN: begin
                // hold until the result register is free, then load it
                if (out_free) begin
                    n_ovalid   = 1'b1;
                    n_o_addr   = r_res_addr;
                    n_o_fail   = r_res_fail;
                    n_o_total  = (r_sum > SUM_W'(LEN_MAX)) ? LEN_MAX : r_sum[LEN_W-1:0];
                    n_o_count  = r_count;
                    n_o_peak   = r_peak;
                    n_o_loss_n = r_loss_n;
                    n_o_loss_p = r_loss_p;
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_peak   <= '0;
            r_sum    <= '0;
            r_loss_n <= '0;
            r_loss_p <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_peak   <= n_peak;
            r_sum    <= n_sum;
            r_loss_n <= n_loss_n;
            r_loss_p <= n_loss_p;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_len      <= n_len;
        r_addr     <= n_addr;
        r_ci       <= n_ci;
        r_j        <= n_j;
        r_k        <= n_k;
        r_kin      <= n_kin;
        r_hasprev  <= n_hasprev;
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_res_addr <= n_res_addr;
        r_res_fail <= n_res_fail;
        r_o_addr   <= n_o_addr;
        r_o_fail   <= n_o_fail;
        r_o_total  <= n_o_total;
        r_o_count  <= n_o_count;
        r_o_peak   <= n_o_peak;
        r_o_loss_n <= n_o_loss_n;
        r_o_loss_p <= n_o_loss_p;
    end

    assign i_in.ready             = (r_state == ST_IDLE);
    assign o_out.valid            = r_ovalid;
    assign o_out.alloc_address    = r_o_addr;
    assign o_out.failed           = r_o_fail;
    assign o_out.free_total       = r_o_total;
    assign o_out.entries_in_use   = r_o_count;
    assign o_out.max_entries_seen = r_o_peak;
    assign o_out.lost_count       = r_o_loss_n;
    assign o_out.lost_paragraphs  = r_o_loss_p;

    `FFA_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= COUNT_W'(FREE_ENTRIES))
    `FFA_ASSERT_IMP(a_peak_cover, i_clk, i_rst_n, 1'b1, r_peak >= r_count)
    `FFA_ASSERT_IMP(a_scan_in_list, i_clk, i_rst_n, r_state == ST_SCAN, COUNT_W'(r_ci) < r_count)
    `FFA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !i_in.ready)

endmodule

// ===== hw/rtl/ffa_ram.sv =====
// Generic single write port RAM with one registered read port.
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
